>>> design/sfd_pkg.sv
// sfd_pkg: shared constants, state encoding and control structs of the slip frame decoder
// no dependencies; used by every module of the block
package sfd_pkg;

  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned LEN_W       = 7;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 7'd64;

  localparam logic [7:0] CODE_END     = 8'hC0;
  localparam logic [7:0] CODE_ESC     = 8'hDB;
  localparam logic [7:0] CODE_ESC_END = 8'hDC;
  localparam logic [7:0] CODE_ESC_ESC = 8'hDD;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DRAIN
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic take_byte;
    logic read_step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_drain;
    logic read_last;
    logic out_free;
  } status_t;

endpackage

>>> design/sfd_if.sv
// sfd_rx_if and sfd_frame_if: valid/ready channels of the slip frame decoder
// no dependencies
interface sfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

>>> design/sfd_ctrl.sv
// sfd_ctrl: state machine that sequences word intake and frame drain
// depends on sfd_pkg
module sfd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sfd_pkg::status_t status_i,
  output sfd_pkg::cmd_t    cmd_o
);

  sfd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sfd_pkg::ST_IDLE: begin
        if (in_valid_i && status_i.start_drain) begin
          state_d = sfd_pkg::ST_DRAIN;
        end
      end
      sfd_pkg::ST_DRAIN: begin
        if (status_i.out_free && status_i.read_last) begin
          state_d = sfd_pkg::ST_IDLE;
        end
      end
      default: state_d = sfd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o.take_byte = 1'b0;
    cmd_o.read_step = 1'b0;
    unique case (state_q)
      sfd_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.take_byte = in_valid_i;
      end
      sfd_pkg::ST_DRAIN: begin
        cmd_o.read_step = status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // no word is taken while a drain is running
  a_no_start_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sfd_pkg::ST_DRAIN) |-> !cmd_o.take_byte)
    else $error("word taken during drain");

  // the last read of a drain returns the controller to intake
  a_last_ends_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.read_step && status_i.read_last) |=> (state_q == sfd_pkg::ST_IDLE))
    else $error("drain did not end after last read");

endmodule

>>> design/sfd_datapath.sv
// sfd_datapath: escape flag, fill count, frame store memory and output register
// depends on sfd_pkg
module sfd_datapath #(
  parameter int unsigned STORE_DEPTH = sfd_pkg::STORE_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [sfd_pkg::LEN_W-1:0] cfg_data_i,
  input  logic [7:0]               rx_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [7:0]               frame_byte_o,
  output logic                     frame_last_o,
  input  sfd_pkg::cmd_t            cmd_i,
  output sfd_pkg::status_t         status_o
);

  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned IW = $clog2(STORE_DEPTH);
  localparam logic [sfd_pkg::LEN_W-1:0] DEPTH_LEN = sfd_pkg::LEN_W'(STORE_DEPTH);

  logic [sfd_pkg::LEN_W-1:0] max_len_q;
  logic                      esc_q, esc_d;
  logic [CW-1:0]             fill_q, fill_d;
  logic [CW-1:0]             rd_cnt_q, rd_cnt_d;
  logic                      out_valid_q, out_valid_d;
  logic                      out_last_q;
  logic [7:0]                rd_data_q;
  logic [7:0]                mem [STORE_DEPTH];

  logic [sfd_pkg::LEN_W-1:0] limit;
  logic                      full;
  logic                      data_byte;
  logic [7:0]                data_val;
  logic                      wr_en;

  assign limit = (max_len_q > DEPTH_LEN) ? DEPTH_LEN : max_len_q;
  assign full  = (sfd_pkg::LEN_W'(fill_q) >= limit);

  // classify the accepted word
  always_comb begin
    data_byte = 1'b0;
    data_val  = rx_byte_i;
    if (esc_q) begin
      if (rx_byte_i == sfd_pkg::CODE_ESC_END) begin
        data_byte = 1'b1;
        data_val  = sfd_pkg::CODE_END;
      end else if (rx_byte_i == sfd_pkg::CODE_ESC_ESC) begin
        data_byte = 1'b1;
        data_val  = sfd_pkg::CODE_ESC;
      end
    end else if (rx_byte_i != sfd_pkg::CODE_ESC && rx_byte_i != sfd_pkg::CODE_END) begin
      data_byte = 1'b1;
    end
  end

  assign wr_en = cmd_i.take_byte && data_byte && !full;

  assign status_o.start_drain = !esc_q && (rx_byte_i == sfd_pkg::CODE_END) && (fill_q != '0);
  assign status_o.read_last   = ((rd_cnt_q + CW'(1)) == fill_q);
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    esc_d       = esc_q;
    fill_d      = fill_q;
    rd_cnt_d    = rd_cnt_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.take_byte) begin
      if (esc_q) begin
        esc_d = 1'b0;
        if (!data_byte || full) begin
          fill_d = '0;
        end else begin
          fill_d = fill_q + CW'(1);
        end
      end else if (rx_byte_i == sfd_pkg::CODE_ESC) begin
        esc_d = 1'b1;
      end else if (rx_byte_i == sfd_pkg::CODE_END) begin
        fill_d = fill_q;
      end else if (full) begin
        fill_d = '0;
      end else begin
        fill_d = fill_q + CW'(1);
      end
    end
    if (cmd_i.read_step) begin
      out_valid_d = 1'b1;
      if (status_o.read_last) begin
        rd_cnt_d = '0;
        fill_d   = '0;
      end else begin
        rd_cnt_d = rd_cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q   <= sfd_pkg::MAX_LEN_RESET;
      esc_q       <= 1'b0;
      fill_q      <= '0;
      rd_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_data_i;
      end
      esc_q       <= esc_d;
      fill_q      <= fill_d;
      rd_cnt_q    <= rd_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // frame store, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[fill_q[IW-1:0]] <= data_val;
    end
    if (cmd_i.read_step) begin
      rd_data_q  <= mem[rd_cnt_q[IW-1:0]];
      out_last_q <= status_o.read_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = rd_data_q;
  assign frame_last_o = out_last_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(STORE_DEPTH))
    else $error("fill count beyond store depth");

  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.read_step |-> (fill_q != '0) && (rd_cnt_q < fill_q))
    else $error("read beyond stored frame");

  a_drain_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.read_step && status_o.read_last) |=> (fill_q == '0) && out_valid_q && out_last_q)
    else $error("last read did not clear store");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.take_byte && cmd_i.read_step))
    else $error("intake and drain at once");

endmodule

>>> design/slip_frame_decoder_top.sv
// slip_frame_decoder_top: slip frame decoder, controller plus datapath
// depends on sfd_pkg, sfd_if (sfd_rx_if, sfd_frame_if), sfd_ctrl, sfd_datapath
//
//  channel   | dir | payload                    | accepted when
//  ----------+-----+----------------------------+----------------------------
//  rx_i      | in  | rx_byte[7:0]               | rx_i.valid && rx_i.ready
//  frame_o   | out | frame_byte[7:0], frame_last | frame_o.valid && frame_o.ready
//  cfg       | in  | cfg_data_i[6:0]            | cfg_we_i
//
// a received word is taken while the block is not draining a frame
// an END word that closes a non-empty frame starts a drain: one stored word per
// cycle is read from the frame store through its single read port into the output
// register while the output is not stalled, so rx_i.ready stays low during the drain
// a stalled output holds the drain; rx_i.ready returns once the last word is read
// reset clears escape flag, fill count and output valid; the store itself is not cleared

module slip_frame_decoder_top #(
  parameter int unsigned STORE_DEPTH = sfd_pkg::STORE_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [sfd_pkg::LEN_W-1:0] cfg_data_i,
  sfd_rx_if.sink                    rx_i,
  sfd_frame_if.source               frame_o
);

  // command and status between controller and datapath
  sfd_pkg::cmd_t    cmd;
  sfd_pkg::status_t status;

  sfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_ready_o (rx_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sfd_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .rx_byte_i    (rx_i.rx_byte),
    .out_valid_o  (frame_o.valid),
    .out_ready_i  (frame_o.ready),
    .frame_byte_o (frame_o.frame_byte),
    .frame_last_o (frame_o.frame_last),
    .cmd_i        (cmd),
    .status_o     (status)
  );

endmodule
